[rtl/core/lse_pkg.sv]
// Shared types and constants for the lattice spin energy engine.
`default_nettype none

package lse_pkg;

  localparam int MAX_SIDE  = 16;
  localparam int NUM_SPINS = 4;

  localparam int COORD_W   = $clog2(MAX_SIDE);
  localparam int SIDE_W    = $clog2(MAX_SIDE + 1);
  localparam int SPIN_W    = 2;
  localparam int DIR_W     = 2;
  localparam int TV_W      = 16;
  localparam int ENERGY_W  = 26;
  localparam int OP_W      = 3;
  localparam int CFG_IDX_W = 2;

  localparam int LAT_AW    = 2 * COORD_W;
  localparam int LAT_DEPTH = 1 << LAT_AW;
  // table index is {own, direction, neighbor}
  localparam int TBL_AW    = SPIN_W + DIR_W + SPIN_W;
  localparam int TBL_DEPTH = 1 << TBL_AW;

  localparam logic [SPIN_W:0]   NUM_SPINS_V = (SPIN_W + 1)'(NUM_SPINS);
  localparam logic [SIDE_W-1:0] MAX_SIDE_V  = SIDE_W'(MAX_SIDE);
  localparam logic [SIDE_W-1:0] SIDE_RESET  = SIDE_W'(10);

  typedef enum logic [OP_W-1:0] {
    OP_LOAD   = 3'd0,
    OP_WRITE  = 3'd1,
    OP_SITE   = 3'd2,
    OP_CHANGE = 3'd3,
    OP_TOTAL  = 3'd4
  } op_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_WIDTH  = 2'd0,
    CFG_HEIGHT = 2'd1,
    CFG_WRAP   = 2'd2
  } cfg_idx_e;

  typedef enum logic [DIR_W-1:0] {
    DIR_RIGHT = 2'd0,
    DIR_UP    = 2'd1,
    DIR_LEFT  = 2'd2,
    DIR_DOWN  = 2'd3
  } dir_e;

  typedef struct packed {
    logic [SIDE_W-1:0] width;
    logic [SIDE_W-1:0] height;
    logic              wrap;
  } cfg_t;

  typedef struct packed {
    logic              re;
    logic              we;
    logic [LAT_AW-1:0] addr;
    logic [SPIN_W-1:0] wdata;
  } lat_req_t;

  typedef struct packed {
    logic              we;
    logic [TBL_AW-1:0] waddr;
    logic [TV_W-1:0]   wdata;
    logic [TBL_AW-1:0] addr_a;
    logic [TBL_AW-1:0] addr_b;
  } tbl_req_t;

  typedef struct packed {
    logic [ENERGY_W-1:0] energy;
    logic [SPIN_W-1:0]   old_spin;
  } res_t;

endpackage

`default_nettype wire

[rtl/core/lattice_spin_energy_engine_top.sv]
// Lattice spin energy engine: config registers, memories, sequencer, output register.
// Table load and undefined or out-of-range ops go straight to the result; site write reads
//   the old spin, then writes; site energy and change add a bond read per bond present.
// Total energy walks every site: own read, then a lattice read and a table read pair per
//   right and up bond present. One request in flight; the next is taken once the result
//   has moved on, while it waits in the output register. Reset: 10x10, open edges.
`default_nettype none

module lattice_spin_energy_engine_top (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  // configuration
  input  wire logic        cfg_we_i,
  input  wire logic [1:0]  cfg_index_i,
  input  wire logic [4:0]  cfg_wdata_i,
  // requests
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  // col[3:0], row[7:4], spin[9:8], direction[11:10], neighbor_spin[13:12],
  // table_value[29:14], zero[31:30]
  input  wire logic [31:0] s_axis_tdata,
  // op[2:0]
  input  wire logic [2:0]  s_axis_tuser,
  // results
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  // energy[25:0], old_spin[27:26], zero[31:28]
  output logic [31:0]      m_axis_tdata
);

  lse_pkg::cfg_t     cfg_q, cfg_d;
  lse_pkg::lat_req_t lat_req;
  lse_pkg::tbl_req_t tbl_req;
  lse_pkg::res_t     res, out_q;
  logic [lse_pkg::SPIN_W-1:0] lat_rdata;
  logic [lse_pkg::TV_W-1:0]   tbl_rdata_a, tbl_rdata_b;
  logic res_valid, res_ready, out_valid_q;
  logic [lse_pkg::SIDE_W-1:0] side_clamped;

  assign side_clamped = (cfg_wdata_i == '0)                ? lse_pkg::SIDE_W'(1) :
                        (cfg_wdata_i > lse_pkg::MAX_SIDE_V) ? lse_pkg::MAX_SIDE_V :
                                                              cfg_wdata_i;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      unique case (cfg_index_i)
        lse_pkg::CFG_WIDTH:  cfg_d.width  = side_clamped;
        lse_pkg::CFG_HEIGHT: cfg_d.height = side_clamped;
        lse_pkg::CFG_WRAP:   cfg_d.wrap   = cfg_wdata_i[0];
        default:             cfg_d        = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.width  <= lse_pkg::SIDE_RESET;
      cfg_q.height <= lse_pkg::SIDE_RESET;
      cfg_q.wrap   <= 1'b0;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  lse_seq u_seq (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_i         (cfg_q),
    .req_valid_i   (s_axis_tvalid),
    .req_ready_o   (s_axis_tready),
    .op_i          (s_axis_tuser),
    .col_i         (s_axis_tdata[3:0]),
    .row_i         (s_axis_tdata[7:4]),
    .spin_i        (s_axis_tdata[9:8]),
    .dir_i         (s_axis_tdata[11:10]),
    .nb_spin_i     (s_axis_tdata[13:12]),
    .tv_i          (s_axis_tdata[29:14]),
    .lat_req_o     (lat_req),
    .lat_rdata_i   (lat_rdata),
    .tbl_req_o     (tbl_req),
    .tbl_rdata_a_i (tbl_rdata_a),
    .tbl_rdata_b_i (tbl_rdata_b),
    .res_valid_o   (res_valid),
    .res_ready_i   (res_ready),
    .res_o         (res)
  );

  lse_lattice u_lattice (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .req_i   (lat_req),
    .rdata_o (lat_rdata)
  );

  lse_table u_table (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .req_i     (tbl_req),
    .rdata_a_o (tbl_rdata_a),
    .rdata_b_o (tbl_rdata_b)
  );

  // output register frees the sequencer while the result waits
  assign res_ready = !out_valid_q || m_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (res_ready) begin
      out_valid_q <= res_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_ready && res_valid) begin
      out_q <= res;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {4'b0000, out_q.old_spin, out_q.energy};

endmodule

`default_nettype wire

[rtl/core/lse_lattice.sv]
// Lattice spin store: single-port synchronous RAM with per-site valid bits.
`default_nettype none

module lse_lattice (
  input  wire logic                    clk_i,
  input  wire logic                    rst_ni,
  input  wire lse_pkg::lat_req_t       req_i,
  output logic [lse_pkg::SPIN_W-1:0]   rdata_o
);

  logic [lse_pkg::SPIN_W-1:0] mem [lse_pkg::LAT_DEPTH];
  logic [lse_pkg::LAT_DEPTH-1:0] valid_q;
  logic [lse_pkg::SPIN_W-1:0] rdata_q;
  logic                       rvalid_q;

  // unwritten sites read as spin zero
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else if (req_i.we) begin
      valid_q[req_i.addr] <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.we) begin
      mem[req_i.addr] <= req_i.wdata;
    end
    if (req_i.re) begin
      rdata_q  <= mem[req_i.addr];
      rvalid_q <= valid_q[req_i.addr];
    end
  end

  assign rdata_o = rvalid_q ? rdata_q : '0;

endmodule

`default_nettype wire

[rtl/core/lse_table.sv]
// Interaction table: synchronous RAM, one write and two read ports, valid bits.
`default_nettype none

module lse_table (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire lse_pkg::tbl_req_t     req_i,
  output logic [lse_pkg::TV_W-1:0]   rdata_a_o,
  output logic [lse_pkg::TV_W-1:0]   rdata_b_o
);

  logic [lse_pkg::TV_W-1:0]      mem [lse_pkg::TBL_DEPTH];
  logic [lse_pkg::TBL_DEPTH-1:0] valid_q;
  logic [lse_pkg::TV_W-1:0]      rdata_a_q, rdata_b_q;
  logic                          rvalid_a_q, rvalid_b_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else if (req_i.we) begin
      valid_q[req_i.waddr] <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.we) begin
      mem[req_i.waddr] <= req_i.wdata;
    end
    rdata_a_q  <= mem[req_i.addr_a];
    rvalid_a_q <= valid_q[req_i.addr_a];
    rdata_b_q  <= mem[req_i.addr_b];
    rvalid_b_q <= valid_q[req_i.addr_b];
  end

  assign rdata_a_o = rvalid_a_q ? rdata_a_q : '0;
  assign rdata_b_o = rvalid_b_q ? rdata_b_q : '0;

endmodule

`default_nettype wire

[rtl/core/lse_seq.sv]
// Operation sequencer: walks bonds, issues memory reads and accumulates energy.
`default_nettype none

module lse_seq (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire lse_pkg::cfg_t                 cfg_i,
  // request from the input side
  input  wire logic                          req_valid_i,
  output logic                               req_ready_o,
  input  wire logic [lse_pkg::OP_W-1:0]      op_i,
  input  wire logic [lse_pkg::COORD_W-1:0]   col_i,
  input  wire logic [lse_pkg::COORD_W-1:0]   row_i,
  input  wire logic [lse_pkg::SPIN_W-1:0]    spin_i,
  input  wire logic [lse_pkg::DIR_W-1:0]     dir_i,
  input  wire logic [lse_pkg::SPIN_W-1:0]    nb_spin_i,
  input  wire logic [lse_pkg::TV_W-1:0]      tv_i,
  // memories
  output lse_pkg::lat_req_t                  lat_req_o,
  input  wire logic [lse_pkg::SPIN_W-1:0]    lat_rdata_i,
  output lse_pkg::tbl_req_t                  tbl_req_o,
  input  wire logic [lse_pkg::TV_W-1:0]      tbl_rdata_a_i,
  input  wire logic [lse_pkg::TV_W-1:0]      tbl_rdata_b_i,
  // result
  output logic                               res_valid_o,
  input  wire logic                          res_ready_i,
  output lse_pkg::res_t                      res_o
);

  typedef enum logic [7:0] {
    S_IDLE   = 8'b0000_0001,
    S_START  = 8'b0000_0010,
    S_OWN_RD = 8'b0000_0100,
    S_OWN_W  = 8'b0000_1000,
    S_NB     = 8'b0001_0000,
    S_NB_W   = 8'b0010_0000,
    S_TB_W   = 8'b0100_0000,
    S_RES    = 8'b1000_0000
  } state_e;

  state_e state_q, state_d;

  logic [lse_pkg::OP_W-1:0]     op_q, op_d;
  logic [lse_pkg::COORD_W-1:0]  c_q, c_d, r_q, r_d;
  logic [lse_pkg::SPIN_W-1:0]   spin_q, spin_d;
  logic [lse_pkg::DIR_W-1:0]    dir_q, dir_d;
  logic [lse_pkg::SPIN_W-1:0]   nbs_q, nbs_d;
  logic [lse_pkg::TV_W-1:0]     tv_q, tv_d;
  logic [lse_pkg::SPIN_W-1:0]   own_q, own_d;
  logic [lse_pkg::DIR_W-1:0]    k_q, k_d;
  logic                         self_q, self_d;
  logic [lse_pkg::ENERGY_W-1:0] acc_q, acc_d;
  lse_pkg::res_t                res_q, res_d;

  // neighbor of the current site in direction k
  logic                         nb_ok;
  logic [lse_pkg::COORD_W-1:0]  nb_c, nb_r;
  logic [lse_pkg::SIDE_W-1:0]   c_inc, r_inc, w_dec, h_dec;
  logic                         in_site, spin_ok, nbs_ok, last_k, site_more;
  logic [lse_pkg::ENERGY_W-1:0] ext_a, ext_b;

  assign c_inc = {1'b0, c_q} + lse_pkg::SIDE_W'(1);
  assign r_inc = {1'b0, r_q} + lse_pkg::SIDE_W'(1);
  assign w_dec = cfg_i.width - lse_pkg::SIDE_W'(1);
  assign h_dec = cfg_i.height - lse_pkg::SIDE_W'(1);

  always_comb begin
    nb_ok = 1'b0;
    nb_c  = c_q;
    nb_r  = r_q;
    unique case (k_q)
      lse_pkg::DIR_RIGHT: begin
        nb_ok = (c_inc < cfg_i.width) || cfg_i.wrap;
        nb_c  = (c_inc < cfg_i.width) ? c_inc[lse_pkg::COORD_W-1:0] : '0;
      end
      lse_pkg::DIR_UP: begin
        nb_ok = (r_inc < cfg_i.height) || cfg_i.wrap;
        nb_r  = (r_inc < cfg_i.height) ? r_inc[lse_pkg::COORD_W-1:0] : '0;
      end
      lse_pkg::DIR_LEFT: begin
        nb_ok = (c_q != '0) || cfg_i.wrap;
        nb_c  = (c_q != '0) ? c_q - lse_pkg::COORD_W'(1) : w_dec[lse_pkg::COORD_W-1:0];
      end
      lse_pkg::DIR_DOWN: begin
        nb_ok = (r_q != '0) || cfg_i.wrap;
        nb_r  = (r_q != '0) ? r_q - lse_pkg::COORD_W'(1) : h_dec[lse_pkg::COORD_W-1:0];
      end
      default: nb_ok = 1'b0;
    endcase
  end

  assign in_site   = ({1'b0, c_q} < cfg_i.width) && ({1'b0, r_q} < cfg_i.height);
  assign spin_ok   = {1'b0, spin_q} < lse_pkg::NUM_SPINS_V;
  assign nbs_ok    = {1'b0, nbs_q} < lse_pkg::NUM_SPINS_V;
  // total energy counts right and up bonds only
  assign last_k    = (op_q == lse_pkg::OP_TOTAL) ? (k_q == lse_pkg::DIR_UP)
                                                 : (k_q == lse_pkg::DIR_DOWN);
  assign site_more = (c_inc < cfg_i.width) || (r_inc < cfg_i.height);

  assign ext_a = {{(lse_pkg::ENERGY_W - lse_pkg::TV_W){tbl_rdata_a_i[lse_pkg::TV_W-1]}},
                  tbl_rdata_a_i};
  assign ext_b = {{(lse_pkg::ENERGY_W - lse_pkg::TV_W){tbl_rdata_b_i[lse_pkg::TV_W-1]}},
                  tbl_rdata_b_i};

  always_comb begin
    logic step;
    step      = 1'b0;
    state_d   = state_q;
    op_d      = op_q;
    c_d       = c_q;
    r_d       = r_q;
    spin_d    = spin_q;
    dir_d     = dir_q;
    nbs_d     = nbs_q;
    tv_d      = tv_q;
    own_d     = own_q;
    k_d       = k_q;
    self_d    = self_q;
    acc_d     = acc_q;
    res_d     = res_q;
    lat_req_o = '0;
    tbl_req_o = '0;
    lat_req_o.addr = {r_q, c_q};

    unique case (state_q)
      S_IDLE: begin
        if (req_valid_i) begin
          op_d    = op_i;
          c_d     = col_i;
          r_d     = row_i;
          spin_d  = spin_i;
          dir_d   = dir_i;
          nbs_d   = nb_spin_i;
          tv_d    = tv_i;
          state_d = S_START;
        end
      end
      S_START: begin
        acc_d   = '0;
        res_d   = '0;
        state_d = S_RES;
        case (op_q)
          lse_pkg::OP_LOAD: begin
            tbl_req_o.we    = spin_ok && nbs_ok;
            tbl_req_o.waddr = {spin_q, dir_q, nbs_q};
            tbl_req_o.wdata = tv_q;
          end
          lse_pkg::OP_WRITE, lse_pkg::OP_SITE, lse_pkg::OP_CHANGE: begin
            if (in_site) state_d = S_OWN_RD;
          end
          lse_pkg::OP_TOTAL: begin
            c_d     = '0;
            r_d     = '0;
            state_d = S_OWN_RD;
          end
          default: state_d = S_RES;
        endcase
      end
      S_OWN_RD: begin
        lat_req_o.re = 1'b1;
        state_d      = S_OWN_W;
      end
      S_OWN_W: begin
        own_d = lat_rdata_i;
        k_d   = lse_pkg::DIR_RIGHT;
        if (op_q == lse_pkg::OP_WRITE) begin
          lat_req_o.we    = spin_ok;
          lat_req_o.wdata = spin_q;
          res_d.old_spin  = lat_rdata_i;
          state_d         = S_RES;
        end else if (op_q == lse_pkg::OP_CHANGE && !spin_ok) begin
          res_d.old_spin  = lat_rdata_i;
          state_d         = S_RES;
        end else begin
          state_d = S_NB;
        end
      end
      S_NB: begin
        if (nb_ok) begin
          lat_req_o.re   = 1'b1;
          lat_req_o.addr = {nb_r, nb_c};
          self_d         = (nb_r == r_q) && (nb_c == c_q);
          state_d        = S_NB_W;
        end else begin
          step = 1'b1;
        end
      end
      S_NB_W: begin
        // port A: bond with the held spin; port B: bond with the new spin,
        // and a site that is its own neighbor sees the new spin there too
        tbl_req_o.addr_a = {own_q, k_q, lat_rdata_i};
        tbl_req_o.addr_b = {spin_q, k_q, self_q ? spin_q : lat_rdata_i};
        state_d          = S_TB_W;
      end
      S_TB_W: begin
        if (op_q == lse_pkg::OP_CHANGE) acc_d = acc_q + ext_b - ext_a;
        else                           acc_d = acc_q + ext_a;
        step = 1'b1;
      end
      S_RES: begin
        if (res_ready_i) state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase

    if (step) begin
      if (!last_k) begin
        k_d     = k_q + lse_pkg::DIR_W'(1);
        state_d = S_NB;
      end else if (op_q == lse_pkg::OP_TOTAL) begin
        if (site_more) begin
          if (c_inc < cfg_i.width) begin
            c_d = c_inc[lse_pkg::COORD_W-1:0];
          end else begin
            c_d = '0;
            r_d = r_inc[lse_pkg::COORD_W-1:0];
          end
          state_d = S_OWN_RD;
        end else begin
          res_d.energy = acc_d;
          state_d      = S_RES;
        end
      end else begin
        // all reads done; the new spin lands only now
        lat_req_o.we    = (op_q == lse_pkg::OP_CHANGE);
        lat_req_o.addr  = {r_q, c_q};
        lat_req_o.wdata = spin_q;
        res_d.energy    = acc_d;
        res_d.old_spin  = own_q;
        state_d         = S_RES;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    op_q   <= op_d;
    c_q    <= c_d;
    r_q    <= r_d;
    spin_q <= spin_d;
    dir_q  <= dir_d;
    nbs_q  <= nbs_d;
    tv_q   <= tv_d;
    own_q  <= own_d;
    k_q    <= k_d;
    self_q <= self_d;
    acc_q  <= acc_d;
    res_q  <= res_d;
  end

  assign req_ready_o = (state_q == S_IDLE);
  assign res_valid_o = (state_q == S_RES);
  assign res_o       = res_q;

endmodule

`default_nettype wire

[dv/lattice_spin_energy_engine_top_tb.sv]
// Self-checking bench for the lattice spin energy engine: scripted ops, then random phases.
`timescale 1ns / 100ps

module lattice_spin_energy_engine_top_tb;
  import lse_pkg::*;

  localparam int WATCHDOG_LIMIT  = 10000;
  localparam int PHASES          = 10;
  localparam int ITEMS_PER_PHASE = 123;
  localparam int SCRIPT_LEN      = 24;
  localparam int MAX_PRINTS      = 20;
  localparam logic [OP_W-1:0] OP_UNDEF_LO = 3'd5;
  localparam logic [OP_W-1:0] OP_UNDEF_HI = 3'd7;
  localparam longint ENERGY_TOP = 33554431;
  localparam longint ENERGY_BOT = -33554432;

  typedef struct packed {
    logic            is_reg;
    cfg_idx_e        reg_idx;
    logic [4:0]      reg_val;
    logic [OP_W-1:0] op;
    logic [3:0]      col;
    logic [3:0]      row;
    logic [1:0]      spin;
    logic [1:0]      dir;
    logic [1:0]      nbr;
    logic [15:0]     tv;
    logic            typed;
    res_t            want;
  } script_row_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_we_i = 1'b0;
  logic [1:0]  cfg_index_i = '0;
  logic [4:0]  cfg_wdata_i = '0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [31:0] s_axis_tdata = '0;
  logic [2:0]  s_axis_tuser = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [31:0] m_axis_tdata;

  lattice_spin_energy_engine_top u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_index_i   (cfg_index_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  initial begin
    forever #2 clk_i = ~clk_i;
  end

  // shadow lattice, coupling table and size registers
  logic [SPIN_W-1:0]      spin_grid [LAT_DEPTH];
  logic signed [TV_W-1:0] coupling  [TBL_DEPTH];
  int   cols_used;
  int   rows_used;
  logic wrap_on;

  res_t        energy_reports_q [$];
  int          err_cnt = 0;
  bit          idle_on = 1'b1;
  script_row_t script [SCRIPT_LEN];

  function automatic int clamp_side(logic [4:0] v);
    if (v == 0) return 1;
    if (v > MAX_SIDE) return MAX_SIDE;
    return int'(v);
  endfunction

  function automatic longint bond(int own, dir_e d, int nb);
    return longint'(coupling[(own * 4 + int'(d)) * NUM_SPINS + nb]);
  endfunction

  function automatic int spin_of(int c, int r);
    return int'(spin_grid[r * MAX_SIDE + c]);
  endfunction

  function automatic longint site_sum(int c, int r, int s);
    longint e;
    e = 0;
    if (c + 1 < cols_used) e += bond(s, DIR_RIGHT, spin_of(c + 1, r));
    else if (wrap_on)      e += bond(s, DIR_RIGHT, spin_of(0, r));
    if (r + 1 < rows_used) e += bond(s, DIR_UP, spin_of(c, r + 1));
    else if (wrap_on)      e += bond(s, DIR_UP, spin_of(c, 0));
    if (c >= 1)            e += bond(s, DIR_LEFT, spin_of(c - 1, r));
    else if (wrap_on)      e += bond(s, DIR_LEFT, spin_of(cols_used - 1, r));
    if (r >= 1)            e += bond(s, DIR_DOWN, spin_of(c, r - 1));
    else if (wrap_on)      e += bond(s, DIR_DOWN, spin_of(c, rows_used - 1));
    return e;
  endfunction

  // right and up bonds only, so each bond is counted once
  function automatic longint lattice_total();
    longint e;
    int     s;
    e = 0;
    for (int r = 0; r < rows_used; r++) begin
      for (int c = 0; c < cols_used; c++) begin
        s = spin_of(c, r);
        if (c + 1 < cols_used) e += bond(s, DIR_RIGHT, spin_of(c + 1, r));
        else if (wrap_on)      e += bond(s, DIR_RIGHT, spin_of(0, r));
        if (r + 1 < rows_used) e += bond(s, DIR_UP, spin_of(c, r + 1));
        else if (wrap_on)      e += bond(s, DIR_UP, spin_of(c, 0));
      end
    end
    return e;
  endfunction

  function automatic res_t apply_op(logic [OP_W-1:0] op, logic [3:0] col, logic [3:0] row,
                                    logic [1:0] spin, logic [1:0] dir, logic [1:0] nbr,
                                    logic [15:0] tv);
    res_t   res;
    longint e;
    int     c;
    int     r;
    int     idx;
    logic [1:0] prev;
    c    = int'(col);
    r    = int'(row);
    idx  = r * MAX_SIDE + c;
    e    = 0;
    prev = '0;
    if (op == OP_LOAD) begin
      coupling[{spin, dir, nbr}] = tv;
    end else if ((op == OP_WRITE || op == OP_SITE || op == OP_CHANGE) &&
                 c < cols_used && r < rows_used) begin
      prev = spin_grid[idx];
      if (op == OP_WRITE) begin
        spin_grid[idx] = spin;
      end else if (op == OP_SITE) begin
        e = site_sum(c, r, int'(prev));
      end else begin
        e = -site_sum(c, r, int'(prev));
        spin_grid[idx] = spin;
        e += site_sum(c, r, int'(spin));
      end
    end else if (op == OP_TOTAL) begin
      e = lattice_total();
    end
    if (e > ENERGY_TOP) e = ENERGY_TOP;
    if (e < ENERGY_BOT) e = ENERGY_BOT;
    res.energy   = ENERGY_W'(e);
    res.old_spin = prev;
    return res;
  endfunction

  function automatic script_row_t op_row(logic [OP_W-1:0] op, int col, int row, int spin,
                                         int dir, int nbr, logic [15:0] tv);
    script_row_t t;
    t = '0;
    t.op   = op;
    t.col  = 4'(col);
    t.row  = 4'(row);
    t.spin = 2'(spin);
    t.dir  = 2'(dir);
    t.nbr  = 2'(nbr);
    t.tv   = tv;
    return t;
  endfunction

  function automatic script_row_t exp_row(logic [OP_W-1:0] op, int col, int row, int spin,
                                          int dir, int nbr, logic [15:0] tv, int e, int o);
    script_row_t t;
    t = op_row(op, col, row, spin, dir, nbr, tv);
    t.typed         = 1'b1;
    t.want.energy   = ENERGY_W'(e);
    t.want.old_spin = 2'(o);
    return t;
  endfunction

  function automatic script_row_t reg_row(cfg_idx_e idx, int val);
    script_row_t t;
    t = '0;
    t.is_reg  = 1'b1;
    t.reg_idx = idx;
    t.reg_val = 5'(val);
    return t;
  endfunction

  task automatic flag_error(string what, longint got, longint want);
    err_cnt++;
    if (err_cnt <= MAX_PRINTS)
      $display("MISMATCH %s: got %0d, want %0d at %0t", what, got, want, $realtime);
  endtask

  task automatic send_op(logic [OP_W-1:0] op, logic [3:0] col, logic [3:0] row,
                         logic [1:0] spin, logic [1:0] dir, logic [1:0] nbr,
                         logic [15:0] tv, logic typed, res_t want);
    res_t pred;
    if (idle_on && $urandom_range(0, 3) == 0) begin
      @(negedge clk_i);
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(0, 4)) @(negedge clk_i);
    end
    @(negedge clk_i);
    s_axis_tdata  <= {2'b00, tv, nbr, dir, spin, row, col};
    s_axis_tuser  <= op;
    s_axis_tvalid <= 1'b1;
    do @(posedge clk_i); while (!s_axis_tready);
    // predictor runs on every accepted request so its state tracks the block
    pred = apply_op(op, col, row, spin, dir, nbr, tv);
    energy_reports_q.push_back(typed ? want : pred);
  endtask

  task automatic settle();
    @(negedge clk_i);
    s_axis_tvalid <= 1'b0;
    while (energy_reports_q.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_reg(cfg_idx_e idx, logic [4:0] val);
    @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_wdata_i <= val;
    @(negedge clk_i);
    cfg_we_i    <= 1'b0;
    case (idx)
      CFG_WIDTH:  cols_used = clamp_side(val);
      CFG_HEIGHT: rows_used = clamp_side(val);
      CFG_WRAP:   wrap_on   = val[0];
      default: ;
    endcase
  endtask

  // result checker
  always @(posedge clk_i) begin : result_check
    res_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (energy_reports_q.size() == 0) begin
        flag_error("unexpected result", longint'($signed(m_axis_tdata[25:0])), 0);
      end else begin
        want = energy_reports_q.pop_front();
        if (m_axis_tdata[25:0] !== want.energy)
          flag_error("energy", longint'($signed(m_axis_tdata[25:0])),
                     longint'($signed(want.energy)));
        if (m_axis_tdata[27:26] !== want.old_spin)
          flag_error("old_spin", longint'(m_axis_tdata[27:26]), longint'(want.old_spin));
      end
    end
  end

  // result-side backpressure in short bursts
  initial begin : sink_stall
    int stall_left;
    stall_left = 0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (stall_left > 0) begin
        m_axis_tready <= 1'b0;
        stall_left--;
      end else begin
        m_axis_tready <= 1'b1;
        if (idle_on && $urandom_range(0, 5) == 0) stall_left = $urandom_range(1, 5);
      end
    end
  end

  // ends the run if nothing moves on either side for too long
  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < WATCHDOG_LIMIT) begin
      @(posedge clk_i);
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) quiet = 0;
      else quiet++;
    end
    $display("tb: failure");
    $finish;
  end

  initial begin : stimulus
    int          pick;
    logic [OP_W-1:0] op;
    logic [3:0]  col;
    logic [3:0]  row;
    logic [15:0] tv;
    int          phase_w    [PHASES];
    int          phase_h    [PHASES];
    int          phase_wrap [PHASES];

    foreach (spin_grid[i]) spin_grid[i] = '0;
    foreach (coupling[i]) coupling[i] = '0;
    cols_used = 10;
    rows_used = 10;
    wrap_on   = 1'b0;

    script = '{
      exp_row(OP_TOTAL, 0, 0, 0, 0, 0, 16'h0000, 0, 0),
      exp_row(OP_LOAD, 0, 0, 0, DIR_RIGHT, 0, 16'h7FFF, 0, 0),
      exp_row(OP_LOAD, 0, 0, 0, DIR_UP, 0, 16'h8000, 0, 0),
      exp_row(OP_LOAD, 15, 15, 3, DIR_DOWN, 3, 16'h8000, 0, 0),
      exp_row(OP_LOAD, 0, 0, 0, DIR_LEFT, 0, 16'h0100, 0, 0),
      exp_row(OP_LOAD, 0, 0, 0, DIR_DOWN, 0, 16'hFFFF, 0, 0),
      op_row(OP_SITE, 0, 0, 0, 0, 0, 16'h0000),
      exp_row(OP_WRITE, 9, 9, 3, 0, 0, 16'h0000, 0, 0),
      // outside the used region: no effect, zero result
      exp_row(OP_WRITE, 10, 0, 1, 0, 0, 16'h0000, 0, 0),
      exp_row(OP_SITE, 15, 15, 0, 0, 0, 16'h0000, 0, 0),
      // change to the spin already held gives zero delta
      exp_row(OP_CHANGE, 9, 9, 3, 0, 0, 16'h0000, 0, 3),
      op_row(OP_CHANGE, 9, 9, 1, 0, 0, 16'h0000),
      exp_row(OP_CHANGE, 0, 10, 2, 0, 0, 16'h0000, 0, 0),
      exp_row(OP_UNDEF_LO, 3, 4, 1, 2, 3, 16'h1234, 0, 0),
      exp_row(OP_UNDEF_HI, 15, 15, 3, 3, 3, 16'hFFFF, 0, 0),
      op_row(OP_TOTAL, 0, 0, 0, 0, 0, 16'h0000),
      reg_row(CFG_WRAP, 1),
      op_row(OP_SITE, 0, 0, 0, 0, 0, 16'h0000),
      // size zero reads as one, oversize as the maximum
      reg_row(CFG_WIDTH, 0),
      reg_row(CFG_HEIGHT, 31),
      // single column with wrap: the site neighbors itself left and right
      op_row(OP_SITE, 0, 5, 0, 0, 0, 16'h0000),
      op_row(OP_CHANGE, 0, 15, 3, 0, 0, 16'h0000),
      op_row(OP_TOTAL, 0, 0, 0, 0, 0, 16'h0000),
      exp_row(OP_SITE, 1, 0, 0, 0, 0, 16'h0000, 0, 0)
    };

    phase_w    = '{10, 16, 16, 1, 1, 16, 0, 31, 0, 0};
    phase_h    = '{10, 16, 16, 1, 16, 1, 31, 0, 0, 0};
    phase_wrap = '{0, 1, 0, 1, 1, 0, 1, 0, 0, 0};
    for (int p = PHASES - 2; p < PHASES; p++) begin
      phase_w[p]    = $urandom_range(2, 16);
      phase_h[p]    = $urandom_range(2, 16);
      phase_wrap[p] = $urandom_range(0, 1);
    end

    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    foreach (script[i]) begin
      if (script[i].is_reg) begin
        settle();
        write_reg(script[i].reg_idx, script[i].reg_val);
      end else begin
        send_op(script[i].op, script[i].col, script[i].row, script[i].spin, script[i].dir,
                script[i].nbr, script[i].tv, script[i].typed, script[i].want);
      end
    end

    for (int p = 0; p < PHASES; p++) begin
      settle();
      write_reg(CFG_WIDTH, 5'(phase_w[p]));
      write_reg(CFG_HEIGHT, 5'(phase_h[p]));
      write_reg(CFG_WRAP, 5'(phase_wrap[p]));
      idle_on = (p != PHASES - 1);
      for (int i = 0; i < ITEMS_PER_PHASE; i++) begin
        pick = $urandom_range(0, 99);
        if (pick < 18)      op = OP_LOAD;
        else if (pick < 36) op = OP_WRITE;
        else if (pick < 60) op = OP_SITE;
        else if (pick < 88) op = OP_CHANGE;
        else if (pick < 93) op = OP_TOTAL;
        else                op = OP_W'($urandom_range(OP_UNDEF_LO, OP_UNDEF_HI));
        // mostly inside the used region, now and then anywhere
        col = ($urandom_range(0, 7) == 0) ? 4'($urandom_range(0, 15))
                                          : 4'($urandom_range(0, cols_used - 1));
        row = ($urandom_range(0, 7) == 0) ? 4'($urandom_range(0, 15))
                                          : 4'($urandom_range(0, rows_used - 1));
        if ($urandom_range(0, 9) == 0) tv = $urandom_range(0, 1) ? 16'h7FFF : 16'h8000;
        else tv = 16'($urandom);
        send_op(op, col, row, 2'($urandom), 2'($urandom), 2'($urandom), tv, 1'b0, '0);
      end
    end

    settle();
    repeat (20) @(posedge clk_i);
    if (err_cnt == 0) $display("tb: success");
    else $display("tb: failure");
    $finish;
  end

endmodule
